@@ hw/rtl/box_width_velocity_average_macros.svh @@
// Assertion macros used by the checker file.
`ifndef BOX_WIDTH_VELOCITY_AVERAGE_MACROS_SVH
`define BOX_WIDTH_VELOCITY_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BWVA_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bwva assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BWVA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bwva assertion failed");

`endif

@@ hw/rtl/bwva_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwva_pkg
// Widths, codes, state type and arithmetic helpers of the box width and
// velocity averager.
// ----------------------------------------------------------------------------
package bwva_pkg;

   localparam int COORD_BITS = 12;
   localparam int MAX_FRAMES = 256;
   localparam int COUNT_BITS = $clog2(MAX_FRAMES) + 1;
   localparam int BOXES_BITS = 8;
   localparam int RATE_BITS  = 16;
   localparam int DIST_BITS  = 24;
   localparam int CSR_BITS   = 24;
   localparam int FRAC_BITS  = 8;
   localparam int SUM_BITS   = 48;
   localparam int AVGW_BITS  = 27;
   localparam int AVGV_BITS  = 30;
   localparam int TERM_BITS  = 32;
   localparam int MUL_BITS   = DIST_BITS + RATE_BITS;
   localparam int DIV_BITS   = SUM_BITS;
   localparam int REM_BITS   = (COORD_BITS > COUNT_BITS) ? COORD_BITS : COUNT_BITS;
   localparam int CNT_BITS   = $clog2(DIV_BITS);

   localparam logic [CNT_BITS-1:0] DIST_LAST = CNT_BITS'(DIST_BITS - 1);
   localparam logic [CNT_BITS-1:0] MUL_LAST  = CNT_BITS'(RATE_BITS - 1);
   localparam logic [CNT_BITS-1:0] TERM_LAST = CNT_BITS'(TERM_BITS - 1);
   localparam logic [CNT_BITS-1:0] AVG_LAST  = CNT_BITS'(DIV_BITS - 1);

   localparam logic signed [SUM_BITS:0] AVGW_HI = (SUM_BITS + 1)'((1 << (AVGW_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS:0] AVGW_LO = (SUM_BITS + 1)'(-(1 << (AVGW_BITS - 1)));
   localparam logic signed [SUM_BITS:0] AVGV_HI = (SUM_BITS + 1)'((1 << (AVGV_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS:0] AVGV_LO = (SUM_BITS + 1)'(-(1 << (AVGV_BITS - 1)));

   localparam logic [BOXES_BITS-1:0] MIN_BOXES_RESET = BOXES_BITS'(3);
   localparam logic [RATE_BITS-1:0]  FRAME_RATE_RESET = RATE_BITS'(15422);
   localparam logic [DIST_BITS-1:0]  DIST_CONST_RESET = DIST_BITS'(6634426);

   typedef enum logic [1:0] {
      CSR_MIN_BOXES,
      CSR_FRAME_RATE,
      CSR_DIST_CONST
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIST,
      ST_MUL_W,
      ST_DIV_W,
      ST_MUL_V,
      ST_DIV_V,
      ST_COMMIT,
      ST_AVG_W,
      ST_AVG_V,
      ST_RESP
   } state_type;

   function automatic logic signed [SUM_BITS-1:0] sat_add_sum(
      input logic signed [SUM_BITS-1:0] a,
      input logic signed [SUM_BITS-1:0] b
   );
      logic signed [SUM_BITS:0] s;
      s = {a[SUM_BITS-1], a} + {b[SUM_BITS-1], b};
      if (s[SUM_BITS] != s[SUM_BITS-1]) begin
         return s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
      end
      return s[SUM_BITS-1:0];
   endfunction

   function automatic logic [SUM_BITS-1:0] abs_sum(input logic signed [SUM_BITS-1:0] s);
      return s[SUM_BITS-1] ? (~s + SUM_BITS'(1)) : s;
   endfunction

   function automatic logic signed [SUM_BITS:0] apply_sign(
      input logic [SUM_BITS-1:0] q,
      input logic                neg
   );
      logic signed [SUM_BITS:0] v;
      v = {1'b0, q};
      return neg ? -v : v;
   endfunction

   function automatic logic signed [AVGW_BITS-1:0] clamp_width(
      input logic signed [SUM_BITS:0] v
   );
      if (v > AVGW_HI) return AVGW_HI[AVGW_BITS-1:0];
      if (v < AVGW_LO) return AVGW_LO[AVGW_BITS-1:0];
      return v[AVGW_BITS-1:0];
   endfunction

   function automatic logic signed [AVGV_BITS-1:0] clamp_vel(
      input logic signed [SUM_BITS:0] v
   );
      if (v > AVGV_HI) return AVGV_HI[AVGV_BITS-1:0];
      if (v < AVGV_LO) return AVGV_LO[AVGV_BITS-1:0];
      return v[AVGV_BITS-1:0];
   endfunction

endpackage

@@ hw/rtl/box_width_velocity_average.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_width_velocity_average
// Per-chain box width and distance rate estimator on a bit-serial datapath.
// ----------------------------------------------------------------------------
// Usage: one request per video frame carries the averaged box edges, the
// match count and a last flag. A frame is valid when box_count reaches
// min_boxes. The frame marked last produces one response with the valid frame
// count, the average width rate, the average velocity and the zero width flag;
// the chain state then clears. Other frames produce no response.
// Timing: all arithmetic runs through one restoring divider (one quotient bit
// per cycle) and one shift-add multiplier (one multiplier bit per cycle).
// A frame divides the distance constant by its width; a valid frame after an
// earlier valid frame adds two multiplies and two divides for its rate terms.
// A last frame adds two divides for the averages and a load of the response.
// The next request is taken only once the block is back in idle.
// Reset clears the chain state, drops any pending response and restores the
// register defaults. A response waits in the output register while rsp_ready
// is low; further requests are still taken, and a following last frame holds
// in its final state until the output register frees. The user must write the
// csr_ registers only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module box_width_velocity_average
   import bwva_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [COORD_BITS-1:0]        req_box_left,
   input  logic [COORD_BITS-1:0]        req_box_right,
   input  logic [BOXES_BITS-1:0]        req_box_count,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [COUNT_BITS-1:0]        rsp_useful_count,
   output logic signed [AVGW_BITS-1:0]  rsp_avg_width_rate,
   output logic signed [AVGV_BITS-1:0]  rsp_avg_velocity,
   output logic                         rsp_zero_width_flag,
   input  logic                         csr_write_en,
   input  logic [1:0]                   csr_index,
   input  logic [CSR_BITS-1:0]          csr_wdata
);

   state_type                   state_ff, state_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic [COORD_BITS-1:0]       width_ff, width_in;
   logic                        valid_ff, valid_in;
   logic                        last_ff, last_in;
   logic [DIST_BITS-1:0]        dist_ff, dist_in;
   logic [DIV_BITS-1:0]         div_q_ff, div_q_in;
   logic [REM_BITS-1:0]         div_r_ff, div_r_in;
   logic [REM_BITS-1:0]         div_d_ff, div_d_in;
   logic [MUL_BITS-1:0]         mul_p_ff, mul_p_in;
   logic [DIST_BITS-1:0]        mul_m_ff, mul_m_in;
   logic                        neg_ff, neg_in;
   logic [COORD_BITS-1:0]       prev_width_ff, prev_width_in;
   logic [DIST_BITS-1:0]        prev_dist_ff, prev_dist_in;
   logic [COUNT_BITS-1:0]       gap_ff, gap_in;
   logic [COUNT_BITS-1:0]       vcount_ff, vcount_in;
   logic                        have_prev_ff, have_prev_in;
   logic signed [SUM_BITS-1:0]  wsum_ff, wsum_in;
   logic signed [SUM_BITS-1:0]  vsum_ff, vsum_in;
   logic                        zero_seen_ff, zero_seen_in;
   logic signed [AVGW_BITS-1:0] avg_w_ff, avg_w_in;
   logic signed [AVGV_BITS-1:0] avg_v_ff, avg_v_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]       rsp_count_ff, rsp_count_in;
   logic signed [AVGW_BITS-1:0] rsp_avg_w_ff, rsp_avg_w_in;
   logic signed [AVGV_BITS-1:0] rsp_avg_v_ff, rsp_avg_v_in;
   logic                        rsp_flag_ff, rsp_flag_in;
   logic [BOXES_BITS-1:0]       min_boxes_ff, min_boxes_in;
   logic [RATE_BITS-1:0]        frame_rate_ff, frame_rate_in;
   logic [DIST_BITS-1:0]        dist_const_ff, dist_const_in;

   logic [COORD_BITS-1:0]       width_c;
   logic [REM_BITS:0]           rem_sh;
   logic [REM_BITS:0]           rem_diff;
   logic                        rem_ge;
   logic [REM_BITS-1:0]         div_r_step;
   logic [DIV_BITS-1:0]         div_q_step;
   logic [DIST_BITS:0]          mul_s;
   logic [MUL_BITS-1:0]         mul_p_step;
   logic [DIST_BITS-1:0]        dist_c;
   logic [COUNT_BITS-1:0]       gap_inc;
   logic [COUNT_BITS-1:0]       vcount_nx;
   logic signed [COORD_BITS:0]  dw;
   logic [COORD_BITS-1:0]       dw_mag;
   logic signed [DIST_BITS:0]   dd;
   logic [DIST_BITS-1:0]        dd_mag;
   logic signed [SUM_BITS:0]    term_full;
   logic signed [SUM_BITS-1:0]  term_c;
   logic signed [SUM_BITS:0]    avg_full;
   logic                        rsp_free;

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_useful_count    = rsp_count_ff;
   assign rsp_avg_width_rate  = rsp_avg_w_ff;
   assign rsp_avg_velocity    = rsp_avg_v_ff;
   assign rsp_zero_width_flag = rsp_flag_ff;

   assign width_c = (req_box_right > req_box_left) ? (req_box_right - req_box_left) : '0;

   assign rem_sh     = {div_r_ff, div_q_ff[DIV_BITS-1]};
   assign rem_ge     = (rem_sh >= {1'b0, div_d_ff});
   assign rem_diff   = rem_sh - {1'b0, div_d_ff};
   assign div_r_step = rem_ge ? rem_diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
   assign div_q_step = {div_q_ff[DIV_BITS-2:0], rem_ge};

   assign mul_s      = {1'b0, mul_p_ff[MUL_BITS-1:RATE_BITS]}
                     + (mul_p_ff[0] ? {1'b0, mul_m_ff} : '0);
   assign mul_p_step = {mul_s, mul_p_ff[RATE_BITS-1:1]};

   assign dist_c  = (width_ff == '0) ? '1 : div_q_step[DIST_BITS-1:0];
   assign gap_inc = (have_prev_ff && (gap_ff < COUNT_BITS'(MAX_FRAMES)))
                  ? gap_ff + COUNT_BITS'(1) : gap_ff;
   assign vcount_nx = (valid_ff && (vcount_ff < COUNT_BITS'(MAX_FRAMES)))
                    ? vcount_ff + COUNT_BITS'(1) : vcount_ff;

   assign dw     = $signed({1'b0, width_ff}) - $signed({1'b0, prev_width_ff});
   assign dw_mag = dw[COORD_BITS] ? COORD_BITS'(-dw) : dw[COORD_BITS-1:0];
   assign dd     = $signed({1'b0, dist_ff}) - $signed({1'b0, prev_dist_ff});
   assign dd_mag = dd[DIST_BITS] ? DIST_BITS'(-dd) : dd[DIST_BITS-1:0];

   assign term_full = apply_sign({{(SUM_BITS-TERM_BITS){1'b0}}, div_q_step[TERM_BITS-1:0]},
                                 neg_ff);
   assign term_c    = $signed(term_full[SUM_BITS-1:0]);
   assign avg_full  = apply_sign(div_q_step, neg_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff + CNT_BITS'(1);
      width_in      = width_ff;
      valid_in      = valid_ff;
      last_in       = last_ff;
      dist_in       = dist_ff;
      div_q_in      = div_q_ff;
      div_r_in      = div_r_ff;
      div_d_in      = div_d_ff;
      mul_p_in      = mul_p_ff;
      mul_m_in      = mul_m_ff;
      neg_in        = neg_ff;
      prev_width_in = prev_width_ff;
      prev_dist_in  = prev_dist_ff;
      gap_in        = gap_ff;
      vcount_in     = vcount_ff;
      have_prev_in  = have_prev_ff;
      wsum_in       = wsum_ff;
      vsum_in       = vsum_ff;
      zero_seen_in  = zero_seen_ff;
      avg_w_in      = avg_w_ff;
      avg_v_in      = avg_v_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_count_in  = rsp_count_ff;
      rsp_avg_w_in  = rsp_avg_w_ff;
      rsp_avg_v_in  = rsp_avg_v_ff;
      rsp_flag_in   = rsp_flag_ff;
      min_boxes_in  = min_boxes_ff;
      frame_rate_in = frame_rate_ff;
      dist_const_in = dist_const_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MIN_BOXES:  min_boxes_in  = csr_wdata[BOXES_BITS-1:0];
            CSR_FRAME_RATE: frame_rate_in = csr_wdata[RATE_BITS-1:0];
            CSR_DIST_CONST: dist_const_in = csr_wdata[DIST_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               width_in = width_c;
               valid_in = (req_box_count >= min_boxes_ff);
               last_in  = req_last;
               div_q_in = {dist_const_ff, {(DIV_BITS-DIST_BITS){1'b0}}};
               div_r_in = '0;
               div_d_in = REM_BITS'(width_c);
               cnt_in   = '0;
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            div_q_in = div_q_step;
            div_r_in = div_r_step;
            if (cnt_ff == DIST_LAST) begin
               dist_in = dist_c;
               gap_in  = gap_inc;
               cnt_in  = '0;
               if (valid_ff && have_prev_ff) begin
                  neg_in   = dw[COORD_BITS];
                  mul_m_in = {{(DIST_BITS-COORD_BITS){1'b0}}, dw_mag};
                  mul_p_in = {{DIST_BITS{1'b0}}, frame_rate_ff};
                  state_in = ST_MUL_W;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_MUL_W: begin
            mul_p_in = mul_p_step;
            if (cnt_ff == MUL_LAST) begin
               div_q_in = {mul_p_step[TERM_BITS-1:0], {(DIV_BITS-TERM_BITS){1'b0}}};
               div_r_in = '0;
               div_d_in = REM_BITS'(gap_ff);
               cnt_in   = '0;
               state_in = ST_DIV_W;
            end
         end
         ST_DIV_W: begin
            div_q_in = div_q_step;
            div_r_in = div_r_step;
            if (cnt_ff == TERM_LAST) begin
               wsum_in  = sat_add_sum(wsum_ff, term_c);
               neg_in   = dd[DIST_BITS];
               mul_m_in = dd_mag;
               mul_p_in = {{DIST_BITS{1'b0}}, frame_rate_ff};
               cnt_in   = '0;
               state_in = ST_MUL_V;
            end
         end
         ST_MUL_V: begin
            mul_p_in = mul_p_step;
            if (cnt_ff == MUL_LAST) begin
               div_q_in = {mul_p_step[FRAC_BITS +: TERM_BITS],
                           {(DIV_BITS-TERM_BITS){1'b0}}};
               div_r_in = '0;
               cnt_in   = '0;
               state_in = ST_DIV_V;
            end
         end
         ST_DIV_V: begin
            div_q_in = div_q_step;
            div_r_in = div_r_step;
            if (cnt_ff == TERM_LAST) begin
               vsum_in  = sat_add_sum(vsum_ff, term_c);
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (valid_ff) begin
               vcount_in     = vcount_nx;
               prev_width_in = width_ff;
               prev_dist_in  = dist_ff;
               gap_in        = '0;
               have_prev_in  = 1'b1;
               if (width_ff == '0) begin
                  zero_seen_in = 1'b1;
               end
            end
            cnt_in = '0;
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (vcount_nx == '0) begin
               avg_w_in = '0;
               avg_v_in = '0;
               state_in = ST_RESP;
            end else begin
               div_q_in = abs_sum(wsum_ff);
               div_r_in = '0;
               div_d_in = REM_BITS'(vcount_nx);
               neg_in   = wsum_ff[SUM_BITS-1];
               state_in = ST_AVG_W;
            end
         end
         ST_AVG_W: begin
            div_q_in = div_q_step;
            div_r_in = div_r_step;
            if (cnt_ff == AVG_LAST) begin
               avg_w_in = clamp_width(avg_full);
               div_q_in = abs_sum(vsum_ff);
               div_r_in = '0;
               neg_in   = vsum_ff[SUM_BITS-1];
               cnt_in   = '0;
               state_in = ST_AVG_V;
            end
         end
         ST_AVG_V: begin
            div_q_in = div_q_step;
            div_r_in = div_r_step;
            if (cnt_ff == AVG_LAST) begin
               avg_v_in = clamp_vel(avg_full);
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = vcount_ff;
               rsp_avg_w_in  = avg_w_ff;
               rsp_avg_v_in  = avg_v_ff;
               rsp_flag_in   = zero_seen_ff;
               prev_width_in = '0;
               prev_dist_in  = '0;
               gap_in        = '0;
               vcount_in     = '0;
               have_prev_in  = 1'b0;
               wsum_in       = '0;
               vsum_in       = '0;
               zero_seen_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         prev_width_ff <= '0;
         prev_dist_ff  <= '0;
         gap_ff        <= '0;
         vcount_ff     <= '0;
         have_prev_ff  <= 1'b0;
         wsum_ff       <= '0;
         vsum_ff       <= '0;
         zero_seen_ff  <= 1'b0;
         min_boxes_ff  <= MIN_BOXES_RESET;
         frame_rate_ff <= FRAME_RATE_RESET;
         dist_const_ff <= DIST_CONST_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_width_ff <= prev_width_in;
         prev_dist_ff  <= prev_dist_in;
         gap_ff        <= gap_in;
         vcount_ff     <= vcount_in;
         have_prev_ff  <= have_prev_in;
         wsum_ff       <= wsum_in;
         vsum_ff       <= vsum_in;
         zero_seen_ff  <= zero_seen_in;
         min_boxes_ff  <= min_boxes_in;
         frame_rate_ff <= frame_rate_in;
         dist_const_ff <= dist_const_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      width_ff     <= width_in;
      valid_ff     <= valid_in;
      last_ff      <= last_in;
      dist_ff      <= dist_in;
      div_q_ff     <= div_q_in;
      div_r_ff     <= div_r_in;
      div_d_ff     <= div_d_in;
      mul_p_ff     <= mul_p_in;
      mul_m_ff     <= mul_m_in;
      neg_ff       <= neg_in;
      avg_w_ff     <= avg_w_in;
      avg_v_ff     <= avg_v_in;
      rsp_count_ff <= rsp_count_in;
      rsp_avg_w_ff <= rsp_avg_w_in;
      rsp_avg_v_ff <= rsp_avg_v_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

endmodule

@@ hw/rtl/bwva_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwva_checker
// Port-level checks of the box width and velocity averager, bound to the top.
// ----------------------------------------------------------------------------
`include "box_width_velocity_average_macros.svh"

module bwva_checker
   import bwva_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [COUNT_BITS-1:0]        rsp_useful_count,
   input logic signed [AVGW_BITS-1:0]  rsp_avg_width_rate,
   input logic signed [AVGV_BITS-1:0]  rsp_avg_velocity,
   input logic                         rsp_zero_width_flag
);

   logic                                          rsp_stall;
   logic                                          req_take;
   logic                                          count_ok;
   logic                                          rsp_empty;
   logic                                          rsp_zeros;
   logic [COUNT_BITS+AVGW_BITS+AVGV_BITS:0]       rsp_fields;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign req_take   = req_valid && req_ready;
   assign count_ok   = (rsp_useful_count <= COUNT_BITS'(MAX_FRAMES));
   assign rsp_empty  = rsp_valid && (rsp_useful_count == '0);
   assign rsp_zeros  = (rsp_avg_width_rate == '0) && (rsp_avg_velocity == '0)
                     && !rsp_zero_width_flag;
   assign rsp_fields = {rsp_useful_count, rsp_avg_width_rate, rsp_avg_velocity,
                        rsp_zero_width_flag};

   `BWVA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_fields))

   `BWVA_ASSERT_NEXT(a_req_single, clock, reset, req_take, !req_ready)

   `BWVA_ASSERT_SAME(a_count_range, clock, reset, rsp_valid, count_ok)

   `BWVA_ASSERT_SAME(a_empty_chain, clock, reset, rsp_empty, rsp_zeros)

endmodule

bind box_width_velocity_average bwva_checker u_bwva_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of box_width_velocity_average. Frame chains go in through the
// request channel, and a local model follows the chain state and configuration
// to work out each chain's average. Every response is compared with that
// average, field by field. The run covers several register settings, long
// chains, and mixes of request gaps and response stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import bwva_pkg::*;

   localparam int     WATCHDOG_LIMIT = 20000;
   localparam int     SETTLE_CYCLES  = 250;
   localparam int     COORD_MAX      = (1 << COORD_BITS) - 1;
   localparam longint SUM_HI         = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_LO         = -SUM_HI - 1;
   localparam longint DIST_SAT       = 16777215;

   typedef struct {
      logic [COUNT_BITS-1:0]       useful_count;
      logic signed [AVGW_BITS-1:0] avg_width_rate;
      logic signed [AVGV_BITS-1:0] avg_velocity;
      logic                        zero_width_flag;
   } chain_average_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [COORD_BITS-1:0]       req_box_left = '0;
   logic [COORD_BITS-1:0]       req_box_right = '0;
   logic [BOXES_BITS-1:0]       req_box_count = '0;
   logic                        req_last = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [COUNT_BITS-1:0]       rsp_useful_count;
   logic signed [AVGW_BITS-1:0] rsp_avg_width_rate;
   logic signed [AVGV_BITS-1:0] rsp_avg_velocity;
   logic                        rsp_zero_width_flag;
   logic                        csr_write_en = 1'b0;
   logic [1:0]                  csr_index = '0;
   logic [CSR_BITS-1:0]         csr_wdata = '0;

   chain_average_type expected_averages[$];
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   int                items_sent = 0;
   int                idle_pct = 0;
   int                stall_pct = 0;

   longint cfg_min_boxes;
   longint cfg_frame_rate;
   longint cfg_dist_const;
   longint last_width;
   longint last_distance;
   longint gap_frames;
   longint valid_frames;
   longint width_rate_sum;
   longint velocity_total;
   bit     have_anchor;
   bit     zero_width_seen;

   box_width_velocity_average u_top (.*);

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic longint sat_sum(input longint v);
      if (v > SUM_HI) return SUM_HI;
      if (v < SUM_LO) return SUM_LO;
      return v;
   endfunction

   function automatic longint clamp_signed(input longint v, input int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic void clear_chain_state();
      last_width      = 0;
      last_distance   = 0;
      gap_frames      = 0;
      valid_frames    = 0;
      width_rate_sum  = 0;
      velocity_total  = 0;
      have_anchor     = 1'b0;
      zero_width_seen = 1'b0;
   endfunction

   function automatic void predict_frame(input longint left, input longint right,
                                         input longint count, input bit last_frame);
      longint            width_px;
      longint            distance;
      longint            gap;
      longint            width_avg;
      longint            velocity_avg;
      chain_average_type result;
      width_px = (right > left) ? right - left : 0;
      distance = (width_px == 0) ? DIST_SAT : cfg_dist_const / width_px;
      if (have_anchor && gap_frames < MAX_FRAMES) gap_frames++;
      if (count >= cfg_min_boxes) begin
         if (width_px == 0) zero_width_seen = 1'b1;
         if (have_anchor) begin
            gap = (gap_frames == 0) ? 1 : gap_frames;
            width_rate_sum = sat_sum(width_rate_sum +
                                     (width_px - last_width) * cfg_frame_rate / gap);
            velocity_total = sat_sum(velocity_total +
                                     (distance - last_distance) * cfg_frame_rate / (gap * 256));
         end
         if (valid_frames < MAX_FRAMES) valid_frames++;
         last_width    = width_px;
         last_distance = distance;
         gap_frames    = 0;
         have_anchor   = 1'b1;
      end
      if (last_frame) begin
         width_avg    = 0;
         velocity_avg = 0;
         if (valid_frames != 0) begin
            width_avg    = clamp_signed(width_rate_sum / valid_frames, AVGW_BITS);
            velocity_avg = clamp_signed(velocity_total / valid_frames, AVGV_BITS);
         end
         result.useful_count    = COUNT_BITS'(valid_frames);
         result.avg_width_rate  = AVGW_BITS'(width_avg);
         result.avg_velocity    = AVGV_BITS'(velocity_avg);
         result.zero_width_flag = zero_width_seen;
         expected_averages.insert(expected_averages.size(), result);
         clear_chain_state();
      end
   endfunction

   task automatic check_average();
      chain_average_type want;
      if (expected_averages.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected response: count %0d width rate %0d velocity %0d flag %0b",
                     rsp_useful_count, rsp_avg_width_rate, rsp_avg_velocity,
                     rsp_zero_width_flag);
         return;
      end
      want = expected_averages.pop_front();
      if (rsp_useful_count !== want.useful_count ||
          rsp_avg_width_rate !== want.avg_width_rate ||
          rsp_avg_velocity !== want.avg_velocity ||
          rsp_zero_width_flag !== want.zero_width_flag) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("response mismatch: expected count %0d width rate %0d velocity %0d flag %0b",
                     want.useful_count, want.avg_width_rate, want.avg_velocity,
                     want.zero_width_flag);
            $display("                   actual   count %0d width rate %0d velocity %0d flag %0b",
                     rsp_useful_count, rsp_avg_width_rate, rsp_avg_velocity,
                     rsp_zero_width_flag);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_average();
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("box_width_velocity_average test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_frame(input logic [COORD_BITS-1:0] left,
                             input logic [COORD_BITS-1:0] right,
                             input logic [BOXES_BITS-1:0] count,
                             input logic last_frame);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_box_left  <= left;
      req_box_right <= right;
      req_box_count <= count;
      req_last      <= last_frame;
      do @(posedge clock); while (!req_ready);
      predict_frame(left, right, count, last_frame);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input longint value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= CSR_BITS'(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_MIN_BOXES:  cfg_min_boxes = value & 64'hFF;
         CSR_FRAME_RATE: cfg_frame_rate = value & 64'hFFFF;
         CSR_DIST_CONST: cfg_dist_const = value & 64'hFF_FFFF;
         default: ;
      endcase
   endtask

   task automatic set_config(input longint min_boxes, input longint rate,
                             input longint dist_const);
      drain_pipeline();
      write_reg(CSR_MIN_BOXES, min_boxes);
      write_reg(CSR_FRAME_RATE, rate);
      write_reg(CSR_DIST_CONST, dist_const);
   endtask

   task automatic send_chain(input int frames, input bit noise);
      logic [COORD_BITS-1:0] left;
      logic [COORD_BITS-1:0] right;
      logic [BOXES_BITS-1:0] count;
      int                    span;
      for (int i = 0; i < frames; i++) begin
         left  = COORD_BITS'($urandom);
         right = COORD_BITS'($urandom);
         count = BOXES_BITS'($urandom);
         if (!noise) begin
            case ($urandom_range(9))
               0: right = left;
               1: right = COORD_BITS'($urandom_range(left));
               default: begin
                  span  = $urandom_range(600, 1);
                  right = COORD_BITS'((left + span > COORD_MAX) ? COORD_MAX : left + span);
               end
            endcase
            if (cfg_min_boxes == 0 || $urandom_range(3) != 0)
               count = BOXES_BITS'($urandom_range(255, cfg_min_boxes));
            else
               count = BOXES_BITS'($urandom_range(cfg_min_boxes - 1, 0));
         end
         send_frame(left, right, count, i == frames - 1);
      end
   endtask

   task automatic test_directed_frames();
      idle_pct  = 0;
      stall_pct = 0;
      send_frame(0, 0, 0, 1'b1);
      send_frame(0, 4095, 255, 1'b0);
      send_frame(100, 50, 3, 1'b0);
      send_frame(10, 11, 2, 1'b0);
      send_frame(0, 1, 3, 1'b1);
      send_frame(4095, 4095, 3, 1'b1);
   endtask

   task automatic test_register_extremes();
      set_config(0, 65535, 16777215);
      send_frame(0, 1, 0, 1'b0);
      send_frame(0, 4095, 0, 1'b1);
      send_frame(0, 4095, 0, 1'b0);
      send_frame(0, 1, 0, 1'b1);
      set_config(255, 0, 0);
      send_frame(0, 200, 254, 1'b0);
      send_frame(0, 300, 255, 1'b0);
      send_frame(7, 6, 255, 1'b1);
      set_config(255, 1, 1);
      send_frame(1, 2, 255, 1'b0);
      send_frame(0, 4095, 255, 1'b1);
   endtask

   task automatic test_long_chains();
      idle_pct  = 0;
      stall_pct = 0;
      set_config(0, $urandom_range(65535, 1), $urandom_range(16777215, 1));
      send_chain(MAX_FRAMES + 3, 1'b0);
      set_config(128, $urandom_range(65535, 1), $urandom_range(16777215, 1));
      send_frame(0, 100, 200, 1'b0);
      repeat (MAX_FRAMES + 4)
         send_frame(COORD_BITS'($urandom), COORD_BITS'($urandom),
                    BOXES_BITS'($urandom_range(127)), 1'b0);
      send_frame(0, 50, 255, 1'b1);
   endtask

   task automatic test_random_traffic(input int idle, input int stall, input int frames);
      int sent_before;
      set_config(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(6),
                 $urandom_range(65535, 1), $urandom_range(16777215, 1));
      idle_pct    = idle;
      stall_pct   = stall;
      sent_before = items_sent;
      while (items_sent - sent_before < frames) begin
         if ($urandom_range(9) == 0)
            send_chain($urandom_range(4, 1), 1'b1);
         else
            send_chain($urandom_range(12, 1), 1'b0);
      end
   endtask

   initial begin
      cfg_min_boxes  = MIN_BOXES_RESET;
      cfg_frame_rate = FRAME_RATE_RESET;
      cfg_dist_const = DIST_CONST_RESET;
      clear_chain_state();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_register_extremes();
      test_long_chains();
      test_random_traffic(0, 0, 115);
      test_random_traffic(81, 0, 115);
      test_random_traffic(0, 81, 115);
      test_random_traffic(13, 13, 115);
      drain_pipeline();
      if (mismatch_count == 0 && expected_averages.size() == 0) begin
         $display("box_width_velocity_average test passed");
      end else begin
         $display("box_width_velocity_average test failed");
      end
      $finish;
   end

endmodule
